// ===== src/json_string_escape_macros.svh =====
// Assertion macros for the JSON string escaper
`ifndef JSON_STRING_ESCAPE_MACROS_SVH
`define JSON_STRING_ESCAPE_MACROS_SVH

`ifndef SYNTHESIS

`define JSE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define JSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define JSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define JSE_ASSERT(lbl, cond, msg)

`define JSE_ASSERT_IMP(lbl, ante, cons, msg)

`define JSE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/jse_pkg.sv =====
// Constants and escape decode functions for the JSON string escaper
`default_nettype none

package jse_pkg;

  localparam int unsigned LEN_W = 3;

  localparam logic [7:0]  CTRL_LIMIT = 8'h20;
  localparam logic [16:0] HEADROOM   = 17'd7;
  localparam logic [15:0] CAP_RESET  = 16'd8192;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_SHORT = 3'd2;
  localparam logic [LEN_W-1:0] LEN_UNI   = 3'd6;

  typedef logic [LEN_W-1:0] len_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h57 + {4'd0, nib};
    end
    return d;
  endfunction

  // second byte of a two-byte escape; 'u' for everything else
  function automatic logic [7:0] esc_letter(input logic [7:0] c);
    logic [7:0] l;
    unique case (c)
      CH_QUOTE: l = 8'h22;
      CH_BSL:   l = 8'h5C;
      CH_LF:    l = 8'h6E;
      CH_CR:    l = 8'h72;
      CH_TAB:   l = 8'h74;
      CH_BS:    l = 8'h62;
      CH_FF:    l = 8'h66;
      default:  l = CH_U;
    endcase
    return l;
  endfunction

  function automatic len_t esc_len(input logic [7:0] c);
    len_t n;
    if (c == CH_NUL) begin
      n = LEN_ONE;
    end else if (esc_letter(c) != CH_U) begin
      n = LEN_SHORT;
    end else if (c < CTRL_LIMIT) begin
      n = LEN_UNI;
    end else begin
      n = LEN_ONE;
    end
    return n;
  endfunction

  function automatic logic [7:0] esc_byte(input logic [7:0] c, input len_t n, input len_t idx);
    logic [7:0] b;
    if (n == LEN_ONE) begin
      b = c;
    end else begin
      unique case (idx)
        3'd0:    b = CH_BSL;
        3'd1:    b = esc_letter(c);
        3'd2:    b = CH_ZERO;
        3'd3:    b = CH_ZERO;
        3'd4:    b = hex_digit(c[7:4]);
        3'd5:    b = hex_digit(c[3:0]);
        default: b = CH_NUL;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/json_string_escape.sv =====
// Streaming JSON string escaper with output capacity limit
//
//  channel  | dir | payload
//  in_*     | in  | tdata[7:0] char_in
//  out_*    | out | tdata[7:0] out_byte, tlast run_end, tuser string_end
//  cfg_*    | in  | wr_data[15:0] output_capacity
//
// Plain bytes and the terminator give one byte, two-byte escapes two and \u
// escapes six; dropped bytes give none. The sequencer sends one output byte per
// cycle; an output stall holds the sequencer and input. Sequencer and output
// register let a new byte enter while the last of the previous sequence leaves.
// Synchronous active-low reset clears count and valids, sets capacity to 8192.
`default_nettype none

module json_string_escape
  import jse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] char_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,    // [7:0] out_byte
  output logic             out_tlast,    // run_end
  output logic             out_tuser,    // string_end
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data   // output_capacity
);

  `include "json_string_escape_macros.svh"

  logic [15:0] cap_r;
  logic [15:0] count_r, count_nxt;
  logic        seq_valid_r, seq_valid_nxt;
  logic [7:0]  seq_char_r, seq_char_nxt;
  len_t        seq_len_r, seq_len_nxt;
  len_t        seq_idx_r, seq_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_end_r, out_end_nxt;

  logic in_fire, room, keep, adv, seq_last, is_term;
  len_t in_len;

  assign room     = ({1'b0, count_r} + HEADROOM) < {1'b0, cap_r};
  assign is_term  = (in_tdata == CH_NUL);
  assign keep     = is_term || room;
  assign in_len   = esc_len(in_tdata);
  assign adv      = seq_valid_r && (!out_valid_r || out_tready);
  assign seq_last = (seq_idx_r == seq_len_r - LEN_ONE);
  assign in_tready = !seq_valid_r || (adv && seq_last);
  assign in_fire  = in_tvalid && in_tready;

  always_comb begin
    seq_valid_nxt = seq_valid_r;
    seq_char_nxt  = seq_char_r;
    seq_len_nxt   = seq_len_r;
    seq_idx_nxt   = seq_idx_r;
    count_nxt     = count_r;
    if (adv) begin
      if (seq_last) begin
        seq_valid_nxt = 1'b0;
      end else begin
        seq_idx_nxt = seq_idx_r + LEN_ONE;
      end
    end
    if (in_fire) begin
      if (is_term) begin
        count_nxt = '0;
      end else if (room) begin
        count_nxt = count_r + {13'd0, in_len};
      end
      if (keep) begin
        seq_valid_nxt = 1'b1;
        seq_char_nxt  = in_tdata;
        seq_len_nxt   = in_len;
        seq_idx_nxt   = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = esc_byte(seq_char_r, seq_len_r, seq_idx_r);
      out_last_nxt  = seq_last;
      out_end_nxt   = (seq_char_r == CH_NUL);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      seq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      seq_valid_r <= seq_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_char_r <= seq_char_nxt;
    seq_len_r  <= seq_len_nxt;
    seq_idx_r  <= seq_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

  `JSE_ASSERT_IMP(a_term_beat, out_tvalid && out_tuser, (out_tdata == CH_NUL) && out_tlast, "terminator beat malformed")
  `JSE_ASSERT(a_count_max, count_r != 16'hFFFF, "byte count overran")
  `JSE_ASSERT_IMP(a_idx_range, seq_valid_r, seq_idx_r < seq_len_r, "sequence index out of range")
  `JSE_ASSERT_NXT(a_term_clear, in_fire && is_term, count_r == 16'd0, "count not cleared by terminator")
  `JSE_ASSERT_NXT(a_drop_hold, in_fire && !keep, count_r == $past(count_r), "dropped byte changed count")

endmodule

`default_nettype wire
